/* design/bol_pkg.sv */
`default_nettype none

package bol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_READ     = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_DUMP     = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FAIL,
    S_MISS,
    S_READ,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FIN_HEAD,
    S_FIN_TAIL,
    S_FIN_REMOVE,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TAIL,
    PTR_IDX,
    PTR_IDX_NEXT,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_HEAD,
    WR_TAIL,
    WR_UP,
    WR_DOWN
  } wr_op_t;

  typedef enum logic [1:0] {
    LEN_HOLD,
    LEN_INC,
    LEN_DEC
  } len_op_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FAIL,
    RES_MISS,
    RES_DATA
  } res_t;

  typedef struct packed {
    logic    load_item;
    ptr_op_t ptr_op;
    wr_op_t  wr_op;
    len_op_t len_op;
    logic    emit;
    res_t    res;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_valid;
    logic idx_is_tail;
    logic ptr_zero;
    logic ptr_at_tail;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/bounded_ordered_list_top.sv */
// Channel  Handshake               Payload
// input    in_valid / in_ready     opcode, item_value, item_index
// output   out_valid / out_ready   result_value, ok, last
//
// An item is decoded on accept. A read, a failed operation, an insert at the tail or
// into an empty list, or a remove of the tail entry then goes straight to its result.
// An insert at the head walks the stored entries one per cycle, from tail to head.
// A remove walks from the entry after the index to the tail.
// A dump emits one item per cycle when out_ready is high.
// Reset empties the list at once; the output register stalls the work when full.
`default_nettype none

module bounded_ordered_list_top #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] item_value,
  input  logic [7:0]         item_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic               ok,
  output logic               last
);

  import bol_pkg::*;

  cmd_t    cmd;
  status_t status;

  bol_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode  (opcode),
    .status  (status),
    .cmd     (cmd)
  );

  bol_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_value  (item_value),
    .item_index  (item_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_value(result_value),
    .ok          (ok),
    .last        (last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Block took a second item right after an accept.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("A result overwrote one that was still waiting.");

  a_no_grow_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.len_op == LEN_INC |-> !status.full)
    else $error("Length grew past capacity.");

  a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.len_op == LEN_DEC |-> !status.empty)
    else $error("Length dropped below zero.");

endmodule

`default_nettype wire

/* design/bol_ram.sv */
`default_nettype none

module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/bol_ctrl.sv */
`default_nettype none

module bol_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       opcode,
  input  bol_pkg::status_t status,
  output bol_pkg::cmd_t    cmd
);

  import bol_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.ptr_op    = PTR_HOLD;
    cmd.wr_op     = WR_NONE;
    cmd.len_op    = LEN_HOLD;
    cmd.emit      = 1'b0;
    cmd.res       = RES_FAIL;
    cmd.last      = 1'b1;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (opcode_t'(opcode))
            OP_INS_HEAD: begin
              if (status.full) begin
                state_next = S_FAIL;
              end else if (status.empty) begin
                state_next = S_FIN_HEAD;
              end else begin
                cmd.ptr_op = PTR_TAIL;
                state_next = S_SHIFT_UP;
              end
            end
            OP_INS_TAIL: begin
              state_next = status.full ? S_FAIL : S_FIN_TAIL;
            end
            OP_READ: begin
              if (status.idx_valid) begin
                cmd.ptr_op = PTR_IDX;
                state_next = S_READ;
              end else begin
                state_next = S_MISS;
              end
            end
            OP_REMOVE: begin
              if (!status.idx_valid) begin
                state_next = S_FAIL;
              end else if (status.idx_is_tail) begin
                state_next = S_FIN_REMOVE;
              end else begin
                cmd.ptr_op = PTR_IDX_NEXT;
                state_next = S_SHIFT_DN;
              end
            end
            OP_DUMP: begin
              if (status.empty) begin
                state_next = S_FAIL;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = S_DUMP;
              end
            end
            default: begin
              state_next = S_FAIL;
            end
          endcase
        end
      end
      S_FAIL, S_MISS: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.res    = (state == S_MISS) ? RES_MISS : RES_FAIL;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.res    = RES_DATA;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_UP: begin
        cmd.wr_op = WR_UP;
        if (status.ptr_zero) begin
          state_next = S_FIN_HEAD;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_SHIFT_DN: begin
        cmd.wr_op = WR_DOWN;
        if (status.ptr_at_tail) begin
          state_next = S_FIN_REMOVE;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_FIN_HEAD, S_FIN_TAIL: begin
        if (status.out_free) begin
          cmd.wr_op  = (state == S_FIN_HEAD) ? WR_HEAD : WR_TAIL;
          cmd.len_op = LEN_INC;
          cmd.emit   = 1'b1;
          cmd.res    = RES_OK;
          state_next = S_IDLE;
        end
      end
      S_FIN_REMOVE: begin
        if (status.out_free) begin
          cmd.len_op = LEN_DEC;
          cmd.emit   = 1'b1;
          cmd.res    = RES_OK;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.res  = RES_DATA;
          cmd.last = status.ptr_at_tail;
          if (status.ptr_at_tail) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/bol_datapath.sv */
`default_nettype none

module bol_datapath #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bol_pkg::cmd_t       cmd,
  output bol_pkg::status_t    status,
  input  logic signed [31:0]  item_value,
  input  logic [7:0]          item_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  result_value,
  output logic                ok,
  output logic                last
);

  import bol_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (LW > 8) ? LW : 8;

  logic [LW-1:0]   len;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   ptr_next;
  logic [31:0]     value_q;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [31:0]     wdata;
  logic [31:0]     rdata;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] idx_ext_p1;
  logic [CMPW-1:0] len_ext;

  assign idx_ext    = CMPW'(item_index);
  assign idx_ext_p1 = idx_ext + CMPW'(1);
  assign len_ext    = CMPW'(len);

  assign status.full        = (len == LW'(CAPACITY));
  assign status.empty       = (len == '0);
  assign status.idx_valid   = (idx_ext < len_ext);
  assign status.idx_is_tail = (idx_ext < len_ext) && (idx_ext_p1 == len_ext);
  assign status.ptr_zero    = (ptr == '0);
  assign status.ptr_at_tail = ((LW'(ptr) + LW'(1)) == len);
  assign status.out_free    = !out_valid || out_ready;

  always_comb begin
    case (cmd.ptr_op)
      PTR_HOLD:     ptr_next = ptr;
      PTR_TAIL:     ptr_next = AW'(len - LW'(1));
      PTR_IDX:      ptr_next = idx_ext[AW-1:0];
      PTR_IDX_NEXT: ptr_next = idx_ext_p1[AW-1:0];
      PTR_ZERO:     ptr_next = '0;
      PTR_INC:      ptr_next = ptr + AW'(1);
      PTR_DEC:      ptr_next = ptr - AW'(1);
      default:      ptr_next = ptr;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = ptr;
    wdata = rdata;
    case (cmd.wr_op)
      WR_NONE: begin
        we = 1'b0;
      end
      WR_HEAD: begin
        waddr = '0;
        wdata = value_q;
      end
      WR_TAIL: begin
        waddr = len[AW-1:0];
        wdata = value_q;
      end
      WR_UP: begin
        waddr = ptr + AW'(1);
      end
      WR_DOWN: begin
        waddr = ptr - AW'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bol_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ptr_next),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load_item) begin
      value_q <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      case (cmd.len_op)
        LEN_INC: len <= len + LW'(1);
        LEN_DEC: len <= len - LW'(1);
        default: len <= len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      case (cmd.res)
        RES_OK: begin
          result_value <= '0;
          ok           <= 1'b1;
        end
        RES_MISS: begin
          result_value <= MISS_VALUE;
          ok           <= 1'b0;
        end
        RES_DATA: begin
          result_value <= rdata;
          ok           <= 1'b1;
        end
        default: begin
          result_value <= '0;
          ok           <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/tb_bounded_ordered_list_top.sv */
module tb_bounded_ordered_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bol_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = CAPACITY + 4;
  localparam int RANDOM_PER_PHASE = 88;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         index;
  } list_cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic               ok;
    logic               last;
  } list_result_t;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BLEND
  } op_mix_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         opcode = '0;
  logic signed [31:0] item_value = '0;
  logic [7:0]         item_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic               ok;
  logic               last;

  logic               in_fire = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 items_accepted = 0;
  int                 results_checked = 0;
  int                 peak_len = 0;

  list_cmd_t          pending_cmds[$];
  list_result_t       expected_results[$];

  logic signed [31:0] shadow_vals[CAPACITY];
  int                 shadow_len = 0;
  int                 planned_len = 0;

  bounded_ordered_list_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .item_value(item_value),
    .item_index(item_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .ok(ok),
    .last(last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void add_expected(input list_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_list_op(input list_cmd_t c);
    list_result_t r;
    list_result_t d;
    bit           single;
    int           i;
    r = '{value: '0, ok: 1'b0, last: 1'b1};
    single = 1'b1;
    case (c.op)
      OP_INS_HEAD: begin
        if (shadow_len < CAPACITY) begin
          for (i = shadow_len; i > 0; i--) shadow_vals[i] = shadow_vals[i - 1];
          shadow_vals[0] = c.value;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_INS_TAIL: begin
        if (shadow_len < CAPACITY) begin
          shadow_vals[shadow_len] = c.value;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (c.index < shadow_len) begin
          r.value = shadow_vals[c.index];
          r.ok = 1'b1;
        end else begin
          r.value = MISS_VALUE;
        end
      end
      OP_REMOVE: begin
        if (c.index < shadow_len) begin
          for (i = c.index; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      OP_DUMP: begin
        if (shadow_len > 0) begin
          single = 1'b0;
          for (i = 0; i < shadow_len; i++) begin
            d = '{value: shadow_vals[i], ok: 1'b1, last: (i == shadow_len - 1)};
            add_expected(d);
          end
        end
      end
      default: begin
      end
    endcase
    if (single) add_expected(r);
    if (shadow_len > peak_len) peak_len = shadow_len;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic signed [31:0] value,
                           input logic [7:0] index);
    list_cmd_t c;
    c = '{op: op, value: value, index: index};
    pending_cmds.insert(pending_cmds.size(), c);
    case (op)
      OP_INS_HEAD, OP_INS_TAIL: if (planned_len < CAPACITY) planned_len++;
      OP_REMOVE: if (index < planned_len) planned_len--;
      default: begin
      end
    endcase
  endtask

  function automatic logic [2:0] pick_op(input op_mix_t mix);
    int r;
    int t_head;
    int t_tail;
    int t_read;
    int t_rem;
    int t_dump;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        t_head = 35; t_tail = 70; t_read = 82; t_rem = 90; t_dump = 98;
      end
      MIX_SHRINK: begin
        t_head = 9; t_tail = 18; t_read = 33; t_rem = 88; t_dump = 98;
      end
      default: begin
        t_head = 18; t_tail = 36; t_read = 58; t_rem = 80; t_dump = 98;
      end
    endcase
    if (r < t_head) return OP_INS_HEAD;
    if (r < t_tail) return OP_INS_TAIL;
    if (r < t_read) return OP_READ;
    if (r < t_rem) return OP_REMOVE;
    if (r < t_dump) return OP_DUMP;
    return 3'(OP_UNUSED_LO + $urandom_range(OP_UNUSED_HI - OP_UNUSED_LO));
  endfunction

  task automatic queue_random_cmds(input int count);
    op_mix_t            mix;
    int                 run_left;
    int                 r;
    logic signed [31:0] value;
    logic [7:0]         index;
    mix = MIX_GROW;
    run_left = $urandom_range(16, 10);
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        mix = op_mix_t'($urandom_range(2));
        run_left = $urandom_range(16, 8);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 85) begin
        value = $urandom;
      end else begin
        case ($urandom_range(3))
          0: value = VAL_MIN;
          1: value = VAL_MAX;
          2: value = '0;
          default: value = -32'sd1;
        endcase
      end
      r = $urandom_range(99);
      if (r < 80) index = 8'($urandom_range(planned_len));
      else if (r < 90) index = (planned_len == 0) ? 8'd0 : 8'(planned_len - 1);
      else index = 8'($urandom_range(255));
      queue_cmd(pick_op(mix), value, index);
    end
  endtask

  task automatic queue_directed_cmds();
    queue_cmd(OP_DUMP, 32'sd0, 8'd0);
    queue_cmd(OP_READ, 32'sd0, 8'd0);
    queue_cmd(OP_READ, 32'sd0, 8'd255);
    queue_cmd(OP_REMOVE, 32'sd0, 8'd0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) queue_cmd(3'(op), VAL_MAX, 8'd0);
    queue_cmd(OP_INS_HEAD, VAL_MIN, 8'd0);
    queue_cmd(OP_INS_TAIL, VAL_MAX, 8'd255);
    queue_cmd(OP_INS_HEAD, -32'sd1, 8'd0);
    queue_cmd(OP_INS_TAIL, 32'sd0, 8'd0);
    queue_cmd(OP_READ, 32'sd0, 8'd0);
    queue_cmd(OP_READ, 32'sd0, 8'd3);
    queue_cmd(OP_READ, 32'sd0, 8'd4);
    queue_cmd(OP_DUMP, 32'sd0, 8'd0);
    queue_cmd(OP_REMOVE, 32'sd0, 8'd3);
    queue_cmd(OP_REMOVE, 32'sd0, 8'd0);
    queue_cmd(OP_REMOVE, 32'sd0, 8'd200);
    queue_cmd(OP_DUMP, 32'sd0, 8'd0);
  endtask

  task automatic wait_until_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_items
    list_cmd_t cmd;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        opcode <= cmd.op;
        item_value <= cmd.value;
        item_index <= cmd.index;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_channels
    list_result_t want;
    in_fire <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: result_value %0d ok %0b last %0b",
                 result_value, ok, last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (result_value !== want.value) begin
            $error("result_value expected %0d actual %0d", want.value, result_value);
            errors++;
          end
          if (ok !== want.ok) begin
            $error("ok expected %0b actual %0b", want.ok, ok);
            errors++;
          end
          if (last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_list_op('{op: opcode, value: item_value, index: item_index});
        items_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 84; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 84; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if (phase == 0) queue_directed_cmds();
      queue_random_cmds(RANDOM_PER_PHASE);
      wait_until_drained();
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("Ran %0d items under four idle patterns and compared %0d results.",
             items_accepted, results_checked);
    $display("The list reached a length of %0d out of %0d entries.", peak_len, CAPACITY);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bol_pkg.sv
design/bol_ram.sv
design/bol_ctrl.sv
design/bol_datapath.sv
design/bounded_ordered_list_top.sv
dv/tb_bounded_ordered_list_top.sv
